### src/bsc_pkg.sv
// Package for the banker's safety check block.
// Holds default sizes and fixed field widths; no dependencies.
`default_nettype none

package bsc_pkg;

  localparam int DEF_MAX_PROCESSES = 16;
  localparam int DEF_UNIT_BITS     = 16;
  localparam int AVAIL_BITS        = 16;
  localparam int INDEX_OUT_BITS    = 4;

endpackage : bsc_pkg

`default_nettype wire

### src/bankers_safety_check.sv
// Banker's safety check, one resource type: load processes, scan passes, emit sequence.
// The item with last_process starts a check that scans the N loaded processes in at
// most N passes, one entry per cycle through the one compare/add unit, then emits one
// result per safe process or one unsafe answer, each held while out_stall is high.
// New items are stalled until the answer is out. Reset (rst_n, synchronous) clears the
// sequencer, counts, done flags, work and available_units; the stores are not cleared.
// Depends on bsc_pkg.
`default_nettype none

module bankers_safety_check #(
  parameter int MAX_PROCESSES = bsc_pkg::DEF_MAX_PROCESSES,
  parameter int UNIT_BITS     = bsc_pkg::DEF_UNIT_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [bsc_pkg::AVAIL_BITS-1:0]     cfg_data,
  // input items
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [UNIT_BITS-1:0]               in_need_units,
  input  wire logic [UNIT_BITS-1:0]               in_held_units,
  input  wire logic                               in_last_process,
  // result items
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_is_safe,
  output logic [bsc_pkg::INDEX_OUT_BITS-1:0]      out_process_index,
  output logic                                    out_end_of_answer
);

  import bsc_pkg::*;

  localparam int IDX_W  = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCESSES + 1);
  localparam int BASE_W = (UNIT_BITS > AVAIL_BITS) ? UNIT_BITS : AVAIL_BITS;
  localparam int WORK_W = BASE_W + $clog2(MAX_PROCESSES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PROCESSES);

  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_CHECK,
    S_SEQ_RD,
    S_EMIT,
    S_UNSAFE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic [CNT_W-1:0]          found_r, found_nxt;
  logic [IDX_W-1:0]          ptr_r, ptr_nxt;
  logic [IDX_W-1:0]          optr_r, optr_nxt;
  logic                      prog_r, prog_nxt;
  logic [MAX_PROCESSES-1:0]  done_r, done_nxt;
  logic [WORK_W-1:0]         work_r, work_nxt;
  logic [AVAIL_BITS-1:0]     avail_r;

  // stores
  logic [UNIT_BITS-1:0]      need_mem [MAX_PROCESSES];
  logic [UNIT_BITS-1:0]      held_mem [MAX_PROCESSES];
  logic [IDX_W-1:0]          seq_mem  [MAX_PROCESSES];
  logic [UNIT_BITS-1:0]      need_q, held_q;
  logic [IDX_W-1:0]          seq_q;

  logic                      in_acc, out_acc;
  logic                      load_wr;
  logic                      seq_wr;
  logic                      elig;
  logic [CNT_W-1:0]          n_last;
  logic [CNT_W-1:0]          ptr_ext, optr_ext;
  logic [IDX_W+3:0]          idx_ext;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (state_r == S_EMIT) || (state_r == S_UNSAFE);
  assign out_acc   = out_valid && !out_stall;
  assign load_wr   = in_acc && (cnt_r < MAX_CNT);

  assign n_last   = cnt_r - 1'b1;
  assign ptr_ext  = CNT_W'(ptr_r);
  assign optr_ext = CNT_W'(optr_r);
  assign idx_ext  = {4'b0000, seq_q};

  assign out_is_safe       = (state_r == S_EMIT);
  assign out_process_index = (state_r == S_EMIT) ? idx_ext[3:0] : '0;
  assign out_end_of_answer = (state_r == S_UNSAFE) || (optr_ext == n_last);

  // the shared compare: need of the current entry against the running work
  assign elig   = !done_r[ptr_r] && ({{(WORK_W-UNIT_BITS){1'b0}}, need_q} <= work_r);
  assign seq_wr = (state_r == S_CHECK) && elig;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    ptr_nxt   = ptr_r;
    optr_nxt  = optr_r;
    prog_nxt  = prog_r;
    done_nxt  = done_r;
    work_nxt  = work_r;
    unique case (state_r)
      S_LOAD: begin
        if (load_wr) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (in_acc && in_last_process) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        // entry 0 is read at this edge, after the final load has landed
        ptr_nxt   = '0;
        found_nxt = '0;
        prog_nxt  = 1'b0;
        done_nxt  = '0;
        work_nxt  = {{(WORK_W-AVAIL_BITS){1'b0}}, avail_r};
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (elig) begin
          work_nxt        = work_r + {{(WORK_W-UNIT_BITS){1'b0}}, held_q};
          done_nxt[ptr_r] = 1'b1;
          found_nxt       = found_r + 1'b1;
        end
        if (elig && (found_r + 1'b1 == cnt_r)) begin
          optr_nxt  = '0;
          state_nxt = S_SEQ_RD;
        end else if (ptr_ext == n_last) begin
          ptr_nxt  = '0;
          prog_nxt = 1'b0;
          if (!(prog_r || elig)) begin
            state_nxt = S_UNSAFE;
          end
        end else begin
          ptr_nxt  = ptr_r + 1'b1;
          prog_nxt = prog_r || elig;
        end
      end
      S_SEQ_RD: begin
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_acc) begin
          if (optr_ext == n_last) begin
            cnt_nxt   = '0;
            done_nxt  = '0;
            state_nxt = S_LOAD;
          end else begin
            optr_nxt  = optr_r + 1'b1;
            state_nxt = S_SEQ_RD;
          end
        end
      end
      S_UNSAFE: begin
        if (out_acc) begin
          cnt_nxt   = '0;
          done_nxt  = '0;
          state_nxt = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      cnt_r   <= '0;
      found_r <= '0;
      ptr_r   <= '0;
      optr_r  <= '0;
      prog_r  <= 1'b0;
      done_r  <= '0;
      work_r  <= '0;
      avail_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      ptr_r   <= ptr_nxt;
      optr_r  <= optr_nxt;
      prog_r  <= prog_nxt;
      done_r  <= done_nxt;
      work_r  <= work_nxt;
      if (cfg_valid && cfg_ready) begin
        avail_r <= cfg_data;
      end
    end
  end

  // process stores: read address runs one entry ahead of the compare
  always_ff @(posedge clk) begin
    if (load_wr) begin
      need_mem[cnt_r[IDX_W-1:0]] <= in_need_units;
      held_mem[cnt_r[IDX_W-1:0]] <= in_held_units;
    end
    need_q <= need_mem[ptr_nxt];
    held_q <= held_mem[ptr_nxt];
  end

  // safe sequence store
  always_ff @(posedge clk) begin
    if (seq_wr) begin
      seq_mem[found_r[IDX_W-1:0]] <= ptr_r;
    end
    seq_q <= seq_mem[optr_r];
  end

endmodule : bankers_safety_check

`default_nettype wire
